// ----- rtl/pointer_to_dense_id_table_unit_macros.svh -----
// assertion macros for the pointer to dense id table unit
`ifndef POINTER_TO_DENSE_ID_TABLE_UNIT_MACROS_SVH
`define POINTER_TO_DENSE_ID_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define PTDIT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PTDIT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ptdit_pkg.sv -----
// shared types and constants for the pointer to dense id table unit
`timescale 1ns / 1ps

package ptdit_pkg;

  localparam int TABLE_DEPTH  = 64;
  localparam int POINTER_BITS = 48;
  localparam int PID_BITS     = 22;
  localparam int LIMIT_BITS   = 32;
  localparam int QUEUE_DEPTH  = 2;
  localparam int IDW          = $clog2(TABLE_DEPTH);
  localparam int LCW          = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] KIND_FREE    = 2'd0;
  localparam logic [1:0] KIND_ALLOC   = 2'd1;
  localparam logic [1:0] KIND_REALLOC = 2'd2;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_FULL    = 3'd3,
    ST_STOP    = 3'd4
  } ptdit_status_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [PID_BITS-1:0]     process_id;
    logic [POINTER_BITS-1:0] old_pointer;
    logic [POINTER_BITS-1:0] new_pointer;
  } ptdit_req_t;

  typedef struct packed {
    logic [IDW-1:0] released_id;
    logic           released_valid;
    logic [IDW-1:0] granted_id;
    logic           granted_valid;
    logic           kept;
    logic [2:0]     status;
    logic [LCW-1:0] peak_live;
  } ptdit_rsp_t;

  // classified event as held in the queue
  typedef struct packed {
    logic                    old_active;
    logic                    new_active;
    logic                    skip;
    logic [PID_BITS-1:0]     pid;
    logic [POINTER_BITS-1:0] old_pointer;
    logic [POINTER_BITS-1:0] new_pointer;
  } ptdit_cls_t;

  typedef struct packed {
    logic       valid;
    ptdit_cls_t item;
  } ptdit_head_t;

  typedef struct packed {
    logic           halted;
    logic [LCW-1:0] live_cnt;
  } ptdit_mon_t;

endpackage

// ----- rtl/ptdit_front.sv -----
// front end: accepts events, classifies them and queues them for the table engine
`timescale 1ns / 1ps

module ptdit_front #(
  parameter int QDEPTH = ptdit_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  ptdit_pkg::ptdit_req_t  req,
  output ptdit_pkg::ptdit_head_t head,
  input  logic                 pop
);
  import ptdit_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  ptdit_cls_t     slot [QDEPTH];
  ptdit_cls_t     cls;
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;

  always_comb begin
    cls.old_active  = ((req.kind == KIND_FREE) || (req.kind == KIND_REALLOC)) &&
                      (req.old_pointer != '0);
    cls.new_active  = (req.kind == KIND_ALLOC) || (req.kind == KIND_REALLOC);
    cls.skip        = (req.kind != KIND_FREE) && (req.kind != KIND_ALLOC) &&
                      (req.kind != KIND_REALLOC);
    cls.pid         = req.process_id;
    cls.old_pointer = req.old_pointer;
    cls.new_pointer = req.new_pointer;
  end

  assign req_stall  = (count == CW'(QDEPTH));
  assign push       = req_valid && !req_stall;
  assign head.valid = (count != '0);
  assign head.item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
  end

endmodule

// ----- rtl/ptdit_back.sv -----
// back end: pointer table, sequential lookup scan, id allocation and result register
`timescale 1ns / 1ps

module ptdit_back (
  input  logic                       clk,
  input  logic                       rst,
  input  ptdit_pkg::ptdit_head_t     head,
  output logic                       pop,
  input  logic                       cfg_wr_en,
  input  logic [ptdit_pkg::LIMIT_BITS-1:0] cfg_wr_data,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output ptdit_pkg::ptdit_rsp_t      rsp,
  output ptdit_pkg::ptdit_mon_t      mon
);
  import ptdit_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_SCAN    = 4'b0010,
    S_TAIL    = 4'b0100,
    S_RESOLVE = 4'b1000
  } state_t;

  localparam logic [IDW-1:0] LAST_ID = IDW'(TABLE_DEPTH - 1);

  logic [POINTER_BITS-1:0] entry_pointer [TABLE_DEPTH];

  state_t                  state;
  logic [TABLE_DEPTH-1:0]  live;
  logic [LCW-1:0]          live_cnt;
  logic [PID_BITS-1:0]     latched_pid;
  logic                    pid_latched;
  logic [LIMIT_BITS-1:0]   items_seen;
  logic [LCW-1:0]          peak;
  logic                    halted;
  logic [LIMIT_BITS-1:0]   op_limit;

  ptdit_cls_t              work;
  logic [IDW-1:0]          scan_cnt;
  logic                    cmp_valid;
  logic [IDW-1:0]          cmp_idx;
  logic [POINTER_BITS-1:0] rd_ptr;
  logic                    old_found;
  logic [IDW-1:0]          old_idx;
  logic                    new_found;
  logic                    free_found;
  logic [IDW-1:0]          free_idx;

  logic                    out_ready;
  logic                    stop_hit;
  logic                    needs_scan;
  logic [LIMIT_BITS-1:0]   items_inc;
  logic [LIMIT_BITS:0]     usage;
  ptdit_status_t           res_status;
  logic                    res_ok;
  logic [LCW-1:0]          live_after;
  logic [PID_BITS-1:0]     c_pid;
  logic [LCW-1:0]          c_live;
  logic                    kept_c;
  logic [LCW-1:0]          peak_c;
  logic                    emit_idle;
  logic                    emit_res;
  logic                    commit_ok;
  logic                    mem_we;
  logic                    cur_live;
  logic                    hit_old;
  logic                    hit_new;
  logic                    is_free;
  ptdit_rsp_t              rsp_next;

  always_comb begin
    out_ready  = !rsp_valid || !rsp_stall;
    usage      = (LIMIT_BITS + 1)'(items_seen) + (LIMIT_BITS + 1)'(live_cnt);
    stop_hit   = !halted && (usage >= (LIMIT_BITS + 1)'(op_limit));
    needs_scan = !halted && !stop_hit && !head.item.skip &&
                 (head.item.old_active || head.item.new_active);
    pop        = head.valid && (state == S_IDLE) && (needs_scan || out_ready);
    items_inc  = (items_seen == '1) ? items_seen : items_seen + LIMIT_BITS'(1);
    emit_idle  = pop && !needs_scan;
    emit_res   = (state == S_RESOLVE) && out_ready;

    // release is checked before the duplicate, which is checked before full
    if (work.old_active && !old_found) begin
      res_status = ST_UNKNOWN;
    end else if (work.new_active && new_found) begin
      res_status = ST_DUP;
    end else if (work.new_active && !free_found) begin
      res_status = ST_FULL;
    end else begin
      res_status = ST_OK;
    end
    res_ok     = (res_status == ST_OK);
    live_after = live_cnt - LCW'(work.old_active) + LCW'(work.new_active);
    mem_we     = emit_res && res_ok && work.new_active;

    c_pid  = (state == S_RESOLVE) ? work.pid : head.item.pid;
    c_live = (state == S_RESOLVE) ? live_after : live_cnt;
    kept_c = !pid_latched || (latched_pid == c_pid);
    peak_c = (kept_c && (c_live > peak)) ? c_live : peak;

    commit_ok = (emit_idle && !halted && !stop_hit && !head.item.skip) ||
                (emit_res && res_ok);

    // compare stage of the scan
    cur_live = live[cmp_idx];
    hit_old  = cur_live && work.old_active && (rd_ptr == work.old_pointer);
    hit_new  = cur_live && work.new_active && (rd_ptr == work.new_pointer) && !hit_old;
    is_free  = !cur_live || hit_old;

    rsp_next           = '0;
    rsp_next.status    = ST_OK;
    rsp_next.peak_live = peak;
    if (emit_idle) begin
      if (halted || stop_hit) begin
        rsp_next.status = ST_STOP;
      end else if (!head.item.skip) begin
        rsp_next.kept      = kept_c;
        rsp_next.peak_live = peak_c;
      end
    end else if (res_ok) begin
      rsp_next.released_id    = work.old_active ? old_idx : '0;
      rsp_next.released_valid = work.old_active;
      rsp_next.granted_id     = work.new_active ? free_idx : '0;
      rsp_next.granted_valid  = work.new_active;
      rsp_next.kept           = kept_c;
      rsp_next.peak_live      = peak_c;
    end else begin
      rsp_next.status = res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      live        <= '0;
      live_cnt    <= '0;
      latched_pid <= '0;
      pid_latched <= 1'b0;
      items_seen  <= '0;
      peak        <= '0;
      halted      <= 1'b0;
      op_limit    <= '1;
      rsp_valid   <= 1'b0;
      cmp_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        op_limit <= cfg_wr_data;
      end
      if (emit_idle || emit_res) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      cmp_valid <= (state == S_SCAN);
      if (commit_ok) begin
        pid_latched <= 1'b1;
        if (!pid_latched) begin
          latched_pid <= c_pid;
        end
        peak <= peak_c;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            if (halted || stop_hit) begin
              halted <= 1'b1;
            end else begin
              items_seen <= items_inc;
              if (needs_scan) begin
                state <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (scan_cnt == LAST_ID) begin
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          state <= S_RESOLVE;
        end
        S_RESOLVE: begin
          if (out_ready) begin
            if (res_ok) begin
              // clear first so a reused id ends up live
              if (work.old_active) begin
                live[old_idx] <= 1'b0;
              end
              if (work.new_active) begin
                live[free_idx] <= 1'b1;
              end
              live_cnt <= live_after;
            end else begin
              halted <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && needs_scan) begin
      work       <= head.item;
      scan_cnt   <= '0;
      old_found  <= 1'b0;
      new_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (state == S_SCAN) begin
      scan_cnt <= scan_cnt + IDW'(1);
    end
    if (cmp_valid) begin
      if (hit_old) begin
        old_found <= 1'b1;
        old_idx   <= cmp_idx;
      end
      if (hit_new) begin
        new_found <= 1'b1;
      end
      if (is_free && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
    end
    if (emit_idle || emit_res) begin
      rsp <= rsp_next;
    end
  end

  // pointer memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_pointer[free_idx] <= work.new_pointer;
    end
    rd_ptr  <= entry_pointer[scan_cnt];
    cmp_idx <= scan_cnt;
  end

  assign mon.halted   = halted;
  assign mon.live_cnt = live_cnt;

endmodule

// ----- rtl/pointer_to_dense_id_table_unit.sv -----
// Top level of the pointer to dense id table unit: front queue plus table engine.
// A stopped, skipped or null-free transaction goes from the queue head straight to
// the result register. A transaction that touches a pointer first runs the scan of
// the pointer memory at one read per cycle, then the tail and resolve states, and
// blocks the engine until it resolves; the rest go at one per cycle if not stalled.
// Synchronous reset clears live bits, counters, pid latch and halt at once.
`timescale 1ns / 1ps

`include "pointer_to_dense_id_table_unit_macros.svh"

module pointer_to_dense_id_table_unit #(
  parameter int QDEPTH = ptdit_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  ptdit_pkg::ptdit_req_t            req,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output ptdit_pkg::ptdit_rsp_t            rsp,
  input  logic                             cfg_wr_en,
  input  logic [ptdit_pkg::LIMIT_BITS-1:0] cfg_wr_data
);
  import ptdit_pkg::*;

  ptdit_head_t head;
  logic        pop;
  ptdit_mon_t  mon;

  ptdit_front #(
    .QDEPTH (QDEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .head      (head),
    .pop       (pop)
  );

  ptdit_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .mon         (mon)
  );

  `PTDIT_ASSERT_IMPL(a_err_clean, clk, rst, rsp_valid && (rsp.status != ST_OK), !rsp.released_valid && !rsp.granted_valid && !rsp.kept, "error transaction carries ids or kept")
  `PTDIT_ASSERT_NEXT(a_halt_sticky, clk, rst, mon.halted, mon.halted, "halt cleared without reset")
  `PTDIT_ASSERT_IMPL(a_stop_halted, clk, rst, rsp_valid && (rsp.status == ST_STOP), mon.halted, "stop reported while not halted")
  `PTDIT_ASSERT_IMPL(a_grant_live, clk, rst, rsp_valid && rsp.granted_valid, (mon.live_cnt != '0) && (mon.live_cnt <= LCW'(TABLE_DEPTH)), "grant without a live entry")

endmodule

// ----- tb/pointer_to_dense_id_table_unit_tb.sv -----
// testbench for the pointer to dense id table unit: directed, random, backpressure and halt traffic
`timescale 1ns / 1ps

module pointer_to_dense_id_table_unit_tb;
  import ptdit_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int WATCHDOG_CYCLES = 3000;
  localparam int SETTLE_CYCLES   = TABLE_DEPTH + 8;
  localparam int HOLD_CYCLES     = 300;
  localparam logic [1:0] KIND_SKIP = 2'd3;
  localparam logic [PID_BITS-1:0] MAIN_PID  = 22'h2A5C3;
  localparam logic [PID_BITS-1:0] OTHER_PID = 22'h3FFFFF;
  localparam logic [POINTER_BITS-1:0] PTR_ONES = '1;

  typedef enum int {
    END_UNKNOWN,
    END_DUP,
    END_FULL,
    END_DUP_FULL,
    END_STOP
  } halt_cause_t;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  ptdit_req_t req;
  logic rsp_valid;
  logic rsp_stall;
  ptdit_rsp_t rsp;
  logic cfg_wr_en;
  logic [LIMIT_BITS-1:0] cfg_wr_data;

  // shadow of the id table
  logic [POINTER_BITS-1:0] slot_ptr [TABLE_DEPTH];
  bit [TABLE_DEPTH-1:0] slot_live;
  bit [PID_BITS-1:0] first_pid;
  bit first_pid_set;
  bit [31:0] event_total;
  bit [LCW-1:0] peak_seen;
  bit table_halted;
  bit [LIMIT_BITS-1:0] limit_reg;

  ptdit_rsp_t id_reports_q[$];
  int error_count;
  int send_idle_pct;
  int sink_idle_pct;
  int hold_request;
  int hold_left;
  bit fill_mode;

  pointer_to_dense_id_table_unit uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int find_slot(input logic [POINTER_BITS-1:0] p);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (slot_live[i] && slot_ptr[i] == p) return i;
    end
    return -1;
  endfunction

  // expected report for one accepted transaction, updates the shadow table
  function automatic ptdit_rsp_t assign_ids(input ptdit_req_t ev);
    ptdit_rsp_t r;
    ptdit_status_t st;
    bit [TABLE_DEPTH-1:0] saved;
    bit kept;
    int hit;
    int slot;
    int n;
    r = '0;
    st = ST_OK;
    kept = 1'b0;
    if (!table_halted &&
        {32'd0, event_total} + 64'($countones(slot_live)) >= {32'd0, limit_reg})
      table_halted = 1'b1;
    if (table_halted) begin
      st = ST_STOP;
    end else begin
      if (event_total != '1) event_total++;
      if (ev.kind != KIND_SKIP) begin
        saved = slot_live;
        if (ev.kind != KIND_ALLOC && ev.old_pointer != '0) begin
          hit = find_slot(ev.old_pointer);
          if (hit < 0) begin
            st = ST_UNKNOWN;
          end else begin
            slot_live[hit] = 1'b0;
            r.released_id = IDW'(hit);
            r.released_valid = 1'b1;
          end
        end
        if (st == ST_OK && ev.kind != KIND_FREE) begin
          if (find_slot(ev.new_pointer) >= 0) begin
            st = ST_DUP;
          end else begin
            slot = -1;
            for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
              if (!slot_live[i]) slot = i;
            end
            if (slot < 0) begin
              st = ST_FULL;
            end else begin
              slot_live[slot] = 1'b1;
              slot_ptr[slot] = ev.new_pointer;
              r.granted_id = IDW'(slot);
              r.granted_valid = 1'b1;
            end
          end
        end
        if (st != ST_OK) begin
          slot_live = saved;
          table_halted = 1'b1;
          r.released_id = '0;
          r.released_valid = 1'b0;
          r.granted_id = '0;
          r.granted_valid = 1'b0;
        end else begin
          if (!first_pid_set) begin
            first_pid_set = 1'b1;
            first_pid = ev.process_id;
            kept = 1'b1;
          end else begin
            kept = (first_pid == ev.process_id);
          end
          if (kept) begin
            n = $countones(slot_live);
            if (n > peak_seen) peak_seen = LCW'(n);
          end
        end
      end
    end
    r.kept = kept;
    r.status = st;
    r.peak_live = peak_seen;
    return r;
  endfunction

  function automatic ptdit_req_t pack_event(input logic [1:0] kind,
                                            input logic [PID_BITS-1:0] pid,
                                            input logic [POINTER_BITS-1:0] oldp,
                                            input logic [POINTER_BITS-1:0] newp);
    ptdit_req_t ev;
    ev.kind = kind;
    ev.process_id = pid;
    ev.old_pointer = oldp;
    ev.new_pointer = newp;
    return ev;
  endfunction

  function automatic logic [POINTER_BITS-1:0] random_pointer();
    return POINTER_BITS'({$urandom, $urandom});
  endfunction

  // pointer that is not live right now; zero shows up now and then
  function automatic logic [POINTER_BITS-1:0] fresh_pointer();
    logic [POINTER_BITS-1:0] p;
    do begin
      case ($urandom_range(3))
        0: p = POINTER_BITS'($urandom_range(255));
        1: p = {16'hFFFF, 32'($urandom)};
        default: p = random_pointer();
      endcase
    end while (find_slot(p) >= 0);
    return p;
  endfunction

  // a live, non-null pointer picked at random, zero when there is none
  function automatic logic [POINTER_BITS-1:0] pick_live_pointer();
    int cands[$];
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (slot_live[i] && slot_ptr[i] != '0) cands.push_back(i);
    end
    if (cands.size() == 0) return '0;
    return slot_ptr[cands[$urandom_range(cands.size() - 1)]];
  endfunction

  // well-formed event that keeps the table error free, with some noise mixed in
  function automatic ptdit_req_t make_event();
    ptdit_req_t ev;
    int unsigned roll;
    int live;
    logic [POINTER_BITS-1:0] victim;
    roll = $urandom_range(99);
    live = $countones(slot_live);
    victim = pick_live_pointer();
    ev.process_id = (first_pid_set && $urandom_range(99) < 88) ? first_pid
                                                                : PID_BITS'($urandom);
    ev.old_pointer = random_pointer();
    ev.new_pointer = random_pointer();
    if (live >= TABLE_DEPTH) fill_mode = 1'b0;
    else if (live <= 2) fill_mode = 1'b1;
    else if ($urandom_range(99) < 2) fill_mode = ~fill_mode;
    if (roll < 6) begin
      ev.kind = KIND_SKIP;
    end else if (roll < 10) begin
      ev.kind = KIND_FREE;
      ev.old_pointer = '0;
    end else if (live < TABLE_DEPTH && ((fill_mode && roll < 75) || (!fill_mode && roll < 30))) begin
      ev.kind = KIND_ALLOC;
      ev.new_pointer = fresh_pointer();
    end else if (victim != '0 && !fill_mode && roll < 80) begin
      ev.kind = KIND_FREE;
      ev.old_pointer = victim;
    end else begin
      ev.kind = KIND_REALLOC;
      if (victim != '0 && (live >= TABLE_DEPTH || $urandom_range(99) < 85))
        ev.old_pointer = victim;
      else
        ev.old_pointer = '0;
      // same pointer back is legal: the old one is released first
      if (ev.old_pointer != '0 && $urandom_range(99) < 15) ev.new_pointer = ev.old_pointer;
      else ev.new_pointer = fresh_pointer();
    end
    return ev;
  endfunction

  // starts and ends at a falling edge; valid stays high unless the next call idles
  task automatic send_event(input ptdit_req_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= ev;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    id_reports_q.push_back(assign_ids(ev));
    @(negedge clk);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (id_reports_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = value;
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_idle_pct = 20;
    sink_idle_pct = 20;
    // skipped kind before any pid is latched
    send_event(pack_event(KIND_SKIP, 22'd7, PTR_ONES, PTR_ONES));
    // null free latches the pid
    send_event(pack_event(KIND_FREE, MAIN_PID, '0, random_pointer()));
    send_event(pack_event(KIND_ALLOC, MAIN_PID, PTR_ONES, '0));
    send_event(pack_event(KIND_ALLOC, MAIN_PID, '0, PTR_ONES));
    send_event(pack_event(KIND_ALLOC, MAIN_PID, '0, 48'h1));
    send_event(pack_event(KIND_ALLOC, OTHER_PID, '0, 48'h0000_1234_5678));
    send_event(pack_event(KIND_ALLOC, 22'd0, '0, 48'h0ABC_0000_0001));
    send_event(pack_event(KIND_FREE, MAIN_PID, PTR_ONES, '0));
    send_event(pack_event(KIND_ALLOC, MAIN_PID, '0, 48'h8000_0000_0000));
    send_event(pack_event(KIND_REALLOC, MAIN_PID, 48'h1, 48'h1));
    send_event(pack_event(KIND_REALLOC, MAIN_PID, '0, 48'h0000_CAFE_F00D));
    send_event(pack_event(KIND_REALLOC, MAIN_PID, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF));
    send_event(pack_event(KIND_REALLOC, OTHER_PID, 48'h7FFF_FFFF_FFFF, 48'h5555_5555_5555));
    send_event(pack_event(KIND_SKIP, MAIN_PID, '0, '0));
    send_event(pack_event(KIND_FREE, MAIN_PID, 48'h5555_5555_5555, PTR_ONES));
    send_event(pack_event(KIND_FREE, OTHER_PID, '0, '0));
    // lower id freed, then a realloc releases a higher one and takes the lowest free id
    send_event(pack_event(KIND_FREE, MAIN_PID, 48'h1, '0));
    send_event(pack_event(KIND_REALLOC, MAIN_PID, 48'h0000_CAFE_F00D, 48'hAAAA_AAAA_AAAA));
    settle();
  endtask

  task automatic test_random_traffic(input int count, input int src_pct, input int snk_pct,
                                     input logic [LIMIT_BITS-1:0] limit);
    int sent;
    ptdit_req_t ev;
    settle();
    write_limit(limit);
    send_idle_pct = src_pct;
    sink_idle_pct = snk_pct;
    sent = 0;
    while (sent < count) begin
      ev = make_event();
      send_event(ev);
      if (ev.kind != KIND_SKIP) sent++;
    end
  endtask

  task automatic test_backpressure();
    settle();
    send_idle_pct = 0;
    sink_idle_pct = 0;
    hold_request = HOLD_CYCLES;
    repeat (16) send_event(make_event());
  endtask

  task automatic test_halt();
    halt_cause_t cause;
    logic [POINTER_BITS-1:0] p;
    int unsigned pick;
    ptdit_req_t ev;
    settle();
    send_idle_pct = 27;
    sink_idle_pct = 27;
    cause = halt_cause_t'($urandom_range(4));
    case (cause)
      END_UNKNOWN: begin
        do p = fresh_pointer(); while (p == '0);
        send_event(pack_event(KIND_FREE, first_pid, p, random_pointer()));
      end
      END_DUP: begin
        if (pick_live_pointer() == '0)
          send_event(pack_event(KIND_ALLOC, first_pid, '0, 48'h0000_0000_0042));
        send_event(pack_event(KIND_ALLOC, first_pid, '0, pick_live_pointer()));
      end
      END_FULL, END_DUP_FULL: begin
        while ($countones(slot_live) < TABLE_DEPTH)
          send_event(pack_event(KIND_ALLOC, first_pid, '0, fresh_pointer()));
        // duplicate wins over full
        p = (cause == END_FULL) ? fresh_pointer() : pick_live_pointer();
        send_event(pack_event(KIND_ALLOC, first_pid, '0, p));
      end
      default: begin
        pick = $urandom_range(2);
        settle();
        if (pick == 0) write_limit('0);
        else write_limit(event_total + $countones(slot_live) + pick - 1);
        send_event(make_event());
        send_event(make_event());
      end
    endcase
    // halted: everything after reports stopped
    repeat (8) begin
      ev.kind = 2'($urandom);
      ev.process_id = $urandom_range(1) ? first_pid : PID_BITS'($urandom);
      ev.old_pointer = random_pointer();
      ev.new_pointer = random_pointer();
      send_event(ev);
    end
  endtask

  // receiver: random stall plus an optional long hold counted here
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else begin
      rsp_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      if (error_count < 10)
        $display("mismatch %s: expected %0h, got %0h", name, exp_v, got_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_reports
    ptdit_rsp_t want;
    if (!rst && rsp_valid === 1'b1 && !rsp_stall) begin
      if (id_reports_q.size() == 0) begin
        if (error_count < 10)
          $display("unexpected transaction on the report side: %h", rsp);
        error_count++;
      end else begin
        want = id_reports_q.pop_front();
        check_field("released_id", 8'(want.released_id), 8'(rsp.released_id));
        check_field("released_valid", 8'(want.released_valid), 8'(rsp.released_valid));
        check_field("granted_id", 8'(want.granted_id), 8'(rsp.granted_id));
        check_field("granted_valid", 8'(want.granted_valid), 8'(rsp.granted_valid));
        check_field("kept", 8'(want.kept), 8'(rsp.kept));
        check_field("status", 8'(want.status), 8'(rsp.status));
        check_field("peak_live", 8'(want.peak_live), 8'(rsp.peak_live));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("[pointer_to_dense_id_table_unit] ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    error_count = 0;
    send_idle_pct = 0;
    sink_idle_pct = 0;
    hold_request = 0;
    hold_left = 0;
    fill_mode = 1'b1;
    slot_live = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) slot_ptr[i] = '0;
    first_pid = '0;
    first_pid_set = 1'b0;
    event_total = '0;
    peak_seen = '0;
    table_halted = 1'b0;
    limit_reg = '1;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    write_limit('1);
    test_directed();
    test_random_traffic(560, 27, 72, '1);
    test_random_traffic(560, 72, 27, event_total + 20000 + $urandom_range(50000));
    test_random_traffic(560, 0, 0, 32'h8000_0000 + $urandom_range(32'h0FFF_FFFF));
    test_backpressure();
    test_halt();
    settle();
    if (error_count == 0 && id_reports_q.size() == 0)
      $display("[pointer_to_dense_id_table_unit] OK");
    else
      $display("[pointer_to_dense_id_table_unit] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ptdit_pkg.sv
rtl/ptdit_front.sv
rtl/ptdit_back.sv
rtl/pointer_to_dense_id_table_unit.sv
tb/pointer_to_dense_id_table_unit_tb.sv
